[hdl/tti_pkg.sv]
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, codes and limit table for the text-to-integer parser.
// ----------------------------------------------------------------------------
package tti_pkg;

  // One input item: a character and its end-of-string mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [63:0] value;
    logic        valid_res;
    logic        overflowed;
  } out_item_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEX_MODE      = 2'd0;
  localparam logic [1:0] CFG_TARGET_SIGNED = 2'd1;
  localparam logic [1:0] CFG_TARGET_WIDE   = 2'd2;

  typedef struct packed {
    logic hex_mode;
    logic target_signed;
    logic target_wide;
  } cfg_t;

  // Parse phases
  localparam logic [1:0] PH_SPACE   = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;

  // Stop reasons
  localparam logic [1:0] STOP_NONE     = 2'd0;
  localparam logic [1:0] STOP_BAD      = 2'd1;
  localparam logic [1:0] STOP_OVERFLOW = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Parser state carried from character to character.
  typedef struct packed {
    logic [1:0]  phase;
    logic [63:0] acc;       // magnitude so far
    logic [63:0] nacc;      // two's complement negation of acc
    logic        neg;
    logic        saw_space;
    logic [1:0]  digit_count;
    logic [1:0]  stop_kind;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_SPACE, acc: 64'd0, nacc: 64'd0, neg: 1'b0,
    saw_space: 1'b0, digit_count: 2'd0, stop_kind: STOP_NONE
  };

  // Magnitude limits per target and sign.
  localparam logic [63:0] LIM_HEX_POS = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LIM_HEX_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIM_U32_POS = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] LIM_U64_POS = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [63:0] Q_HEX_POS = LIM_HEX_POS / 64'd16;
  localparam logic [63:0] Q_HEX_NEG = LIM_HEX_NEG / 64'd16;
  localparam logic [63:0] Q_S32_POS = LIM_S32_POS / 64'd10;
  localparam logic [63:0] Q_S32_NEG = LIM_S32_NEG / 64'd10;
  localparam logic [63:0] Q_S64_POS = LIM_S64_POS / 64'd10;
  localparam logic [63:0] Q_S64_NEG = LIM_S64_NEG / 64'd10;
  localparam logic [63:0] Q_U32_POS = LIM_U32_POS / 64'd10;
  localparam logic [63:0] Q_U64_POS = LIM_U64_POS / 64'd10;

  localparam logic [3:0] R_HEX_POS = 4'(LIM_HEX_POS % 64'd16);
  localparam logic [3:0] R_HEX_NEG = 4'(LIM_HEX_NEG % 64'd16);
  localparam logic [3:0] R_S32_POS = 4'(LIM_S32_POS % 64'd10);
  localparam logic [3:0] R_S32_NEG = 4'(LIM_S32_NEG % 64'd10);
  localparam logic [3:0] R_S64_POS = 4'(LIM_S64_POS % 64'd10);
  localparam logic [3:0] R_S64_NEG = 4'(LIM_S64_NEG % 64'd10);
  localparam logic [3:0] R_U32_POS = 4'(LIM_U32_POS % 64'd10);
  localparam logic [3:0] R_U64_POS = 4'(LIM_U64_POS % 64'd10);

  localparam logic [63:0] NLIM_HEX = 64'd0 - LIM_HEX_NEG;
  localparam logic [63:0] NLIM_S32 = 64'd0 - LIM_S32_NEG;
  localparam logic [63:0] NLIM_S64 = 64'd0 - LIM_S64_NEG;

  typedef struct packed {
    logic [63:0] lim;   // saturated magnitude
    logic [63:0] nlim;  // its negation, used when the sign is minus
    logic [63:0] q;     // lim / base
    logic [3:0]  r;     // lim % base
  } limit_t;

  function automatic limit_t limit_of(cfg_t cfg, logic neg);
    limit_t l;
    l = '0;
    if (cfg.hex_mode) begin
      if (neg) l = '{lim: LIM_HEX_NEG, nlim: NLIM_HEX, q: Q_HEX_NEG, r: R_HEX_NEG};
      else     l = '{lim: LIM_HEX_POS, nlim: 64'd0, q: Q_HEX_POS, r: R_HEX_POS};
    end else if (cfg.target_signed) begin
      if (cfg.target_wide) begin
        if (neg) l = '{lim: LIM_S64_NEG, nlim: NLIM_S64, q: Q_S64_NEG, r: R_S64_NEG};
        else     l = '{lim: LIM_S64_POS, nlim: 64'd0, q: Q_S64_POS, r: R_S64_POS};
      end else begin
        if (neg) l = '{lim: LIM_S32_NEG, nlim: NLIM_S32, q: Q_S32_NEG, r: R_S32_NEG};
        else     l = '{lim: LIM_S32_POS, nlim: 64'd0, q: Q_S32_POS, r: R_S32_POS};
      end
    end else if (neg) begin
      l = '{lim: 64'd0, nlim: 64'd0, q: 64'd0, r: 4'd0};
    end else if (cfg.target_wide) begin
      l = '{lim: LIM_U64_POS, nlim: 64'd0, q: Q_U64_POS, r: R_U64_POS};
    end else begin
      l = '{lim: LIM_U32_POS, nlim: 64'd0, q: Q_U32_POS, r: R_U32_POS};
    end
    return l;
  endfunction

endpackage

[hdl/tti_step.sv]
// ----------------------------------------------------------------------------
// tti_step
// Next-state and result logic for one character of the parser.
// ----------------------------------------------------------------------------
module tti_step (
  input  tti_pkg::cfg_t         cfg,
  input  tti_pkg::parse_state_t st,
  input  tti_pkg::in_item_t     item,
  output tti_pkg::parse_state_t st_nxt,
  output tti_pkg::out_item_t    result
);
  import tti_pkg::*;

  logic          is_blank;
  logic          is_dec;
  logic          is_hex_alpha;
  logic          is_digit;
  logic [3:0]    dval;
  logic          is_x;
  limit_t        lim;
  logic          over;
  logic [63:0]   acc_mul;
  logic [63:0]   nacc_mul;
  logic [63:0]   dext;
  logic [63:0]   mask;
  parse_state_t  s;
  logic          take;
  logic          ok;

  assign is_blank     = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
  assign is_dec       = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign is_hex_alpha = ((item.ch >= CH_LO_A) && (item.ch <= CH_LO_F)) ||
                        ((item.ch >= CH_UP_A) && (item.ch <= CH_UP_F));
  assign is_digit     = is_dec || (cfg.hex_mode && is_hex_alpha);
  assign dval         = is_dec ? item.ch[3:0] : item.ch[3:0] + 4'd9;
  assign dext         = {60'd0, dval};
  assign is_x         = (item.ch == CH_LO_X) || (item.ch == CH_UP_X);

  // Sign only changes before the first digit, so the current sign is the one
  // that applies to this digit.
  assign lim  = limit_of(cfg, st.neg);
  assign over = (st.acc > lim.q) || ((st.acc == lim.q) && (dval > lim.r));

  // Scale by the radix with shifts and adds.
  assign acc_mul  = cfg.hex_mode ? ({st.acc[59:0], 4'd0} + dext)
                                 : ({st.acc[60:0], 3'd0} + {st.acc[62:0], 1'b0} + dext);
  assign nacc_mul = cfg.hex_mode ? ({st.nacc[59:0], 4'd0} - dext)
                                 : ({st.nacc[60:0], 3'd0} + {st.nacc[62:0], 1'b0} - dext);

  assign mask = (!cfg.hex_mode && cfg.target_wide) ? {64{1'b1}} : {32'd0, {32{1'b1}}};

  always_comb begin
    s    = st;
    take = 1'b0;
    case (st.phase)
      PH_SPACE: begin
        if (is_blank) begin
          s.saw_space = 1'b1;
        end else if (item.ch == CH_MINUS) begin
          s.neg   = 1'b1;
          s.phase = PH_DIGITS;
        end else if (item.ch == CH_PLUS) begin
          s.phase = PH_DIGITS;
        end else begin
          s.phase = PH_DIGITS;
          take    = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      default:   take = 1'b0;
    endcase

    if (take) begin
      if (cfg.hex_mode && (st.digit_count == 2'd1) && (st.acc == 64'd0) &&
          is_x && !item.last) begin
        s.digit_count = 2'd2;
      end else if (!is_digit) begin
        s.phase     = PH_STOPPED;
        s.stop_kind = STOP_BAD;
      end else if (over) begin
        s.acc       = lim.lim;
        s.nacc      = lim.nlim;
        s.phase     = PH_STOPPED;
        s.stop_kind = STOP_OVERFLOW;
      end else begin
        s.acc  = acc_mul;
        s.nacc = nacc_mul;
        if (st.digit_count != 2'd2) begin
          s.digit_count = st.digit_count + 2'd1;
        end
      end
    end

    ok = !s.saw_space && (s.stop_kind == STOP_NONE) && (s.digit_count != 2'd0) &&
         (s.phase != PH_SPACE);
    result.value      = (s.neg ? s.nacc : s.acc) & mask;
    result.valid_res  = ok;
    result.overflowed = (s.stop_kind == STOP_OVERFLOW);

    // Drop back to the start state once the string ends.
    st_nxt = item.last ? STATE_RESET : s;
  end

endmodule

[hdl/text_to_integer_parser.sv]
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming saturating string-to-integer parser, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on the in_ channel (in_valid / in_stall, payload in_data
//   with ch and last). Every character is one item; the item with last set
//   closes the string and produces exactly one result item on the out_
//   channel (out_valid / out_stall, payload out_data: value, valid_res,
//   overflowed). Other characters produce no result.
//   Configuration (hex_mode, target_signed, target_wide) is written through
//   cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write it only while no string is in flight.
//   Order: an accepted character is held in the input register, then the
//   step logic updates the parser state; a final character also loads the
//   result register, which drives out_valid, once that register is free.
//   Throughput: one character per cycle while in_stall is low, as the step
//   logic moves each character from the input register into the state and
//   result registers.
//   Stall: a closing character waits in the input register while an earlier
//   result is still held by out_stall; in_stall rises only in that case.
//   Reset (rst_n low, synchronous): registers return to hex_mode 0,
//   target_signed 1, target_wide 0; parser state is cleared and no item is
//   held on either side.
// ----------------------------------------------------------------------------
module text_to_integer_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tti_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tti_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);
  import tti_pkg::*;

  cfg_t         cfg_r;
  cfg_t         cfg_nxt;
  logic         s1_valid_r;
  logic         s1_valid_nxt;
  in_item_t     s1_data_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  out_item_t    step_result;
  logic         out_valid_r;
  logic         out_valid_nxt;
  out_item_t    out_data_r;
  logic         in_accept;
  logic         s1_adv;
  logic         cfg_write;

  // Configuration registers: always ready, out-of-range indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEX_MODE:      cfg_nxt.hex_mode      = cfg_data;
        CFG_TARGET_SIGNED: cfg_nxt.target_signed = cfg_data;
        CFG_TARGET_WIDE:   cfg_nxt.target_wide   = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // A held item advances unless it closes a string and the result slot is
  // still occupied by a stalled item.
  assign s1_adv    = s1_valid_r && !(s1_data_r.last && out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  tti_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_data_r),
    .st_nxt (st_nxt),
    .result (step_result)
  );

  // Result slot: load on a closing character, hold while stalled.
  assign out_valid_nxt = (s1_adv && s1_data_r.last) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{hex_mode: 1'b0, target_signed: 1'b1, target_wide: 1'b0};
      s1_valid_r  <= 1'b0;
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_data_r.last) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A clean result never carries the overflow flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.valid_res && out_data_r.overflowed))
    else $error("result both valid and overflowed");

  // Input backpressure only comes from a blocked closing character.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_data_r.last && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // Parser state restarts after every closing character.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_data_r.last) |=> (st_r.phase == PH_SPACE) && (st_r.acc == 64'd0)
                                   && (st_r.stop_kind == STOP_NONE))
    else $error("parser state not cleared after string end");

  // A result that was stalled is still offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost or changed");

endmodule

[dv/text_to_integer_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_to_integer_parser_test
// Feeds strings to the parser one character per item. A short table of
// corner strings goes first, then random strings under changing target
// types and idle patterns. A behavioral parser or a typed table row gives
// each expected result; each result from the block is compared field by field.
// ----------------------------------------------------------------------------
module text_to_integer_parser_test;
  import tti_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 60;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 4;    // margin after the last owed result
  localparam int PHASE_CHARS  = 70;   // characters per random phase
  localparam int BURST_ITEMS  = 16;   // one-digit strings sent into a hold-off

  // Target settings: {hex_mode, target_signed, target_wide}
  localparam cfg_t MODE_U32 = 3'b000;
  localparam cfg_t MODE_U64 = 3'b001;
  localparam cfg_t MODE_I32 = 3'b010;
  localparam cfg_t MODE_I64 = 3'b011;
  localparam cfg_t MODE_HEX = 3'b111;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic      cfg_data;

  text_to_integer_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral parser: register copy and per-string state, reset values.
  // --------------------------------------------------------------------------
  cfg_t        shadow_cfg = MODE_I32;
  logic [1:0]  pr_phase   = PH_SPACE;
  logic [63:0] pr_acc     = '0;      // magnitude so far
  logic        pr_neg     = 1'b0;
  logic        pr_space   = 1'b0;
  logic [1:0]  pr_count   = 2'd0;    // digits after the sign, stops at two
  logic [1:0]  pr_stop    = STOP_NONE;

  out_item_t   pending_numbers[$];   // parsed numbers still owed by the block
  logic [7:0]  str_buf[$];           // string about to be sent
  bit          pin_next;             // use the table's number for this string
  out_item_t   pinned;
  int          bad_results;
  int          send_pct;
  int          recv_pct;
  int          holds_asked;

  typedef struct {
    string     text;
    cfg_t      mode;
    bit        typed;
    out_item_t want;
  } str_case_t;

  str_case_t dir_rows[$];

  // Largest magnitude the target allows for the given sign.
  function automatic logic [63:0] magnitude_cap(cfg_t m, logic neg);
    if (m.hex_mode)
      return neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_FFFF_FFFF;
    if (m.target_signed) begin
      if (m.target_wide)
        return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    end
    if (neg)
      return 64'd0;
    return m.target_wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  endfunction

  // Fold one character of the digit region into the magnitude.
  function automatic void take_digit(logic [7:0] c, logic lst);
    logic [63:0] base;
    logic [63:0] cap;
    logic [63:0] quot;
    logic [63:0] rem;
    logic [63:0] d;
    bit          is_digit;
    base = shadow_cfg.hex_mode ? 64'd16 : 64'd10;
    // Skip a 0x prefix, but only when something follows the x.
    if (shadow_cfg.hex_mode && pr_count == 2'd1 && pr_acc == 64'd0 &&
        (c == CH_LO_X || c == CH_UP_X) && !lst) begin
      pr_count = 2'd2;
      return;
    end
    is_digit = 1'b1;
    d = 64'd0;
    if (c >= CH_ZERO && c <= CH_NINE)
      d = 64'(c - CH_ZERO);
    else if (shadow_cfg.hex_mode && c >= CH_LO_A && c <= CH_LO_F)
      d = 64'(c - CH_LO_A) + 64'd10;
    else if (shadow_cfg.hex_mode && c >= CH_UP_A && c <= CH_UP_F)
      d = 64'(c - CH_UP_A) + 64'd10;
    else
      is_digit = 1'b0;
    if (!is_digit) begin
      pr_phase = PH_STOPPED;
      pr_stop  = STOP_BAD;
      return;
    end
    cap  = magnitude_cap(shadow_cfg, pr_neg);
    quot = cap / base;
    rem  = cap % base;
    // Saturate before the multiply would pass the cap.
    if (pr_acc > quot || (pr_acc == quot && d > rem)) begin
      pr_acc   = cap;
      pr_phase = PH_STOPPED;
      pr_stop  = STOP_OVERFLOW;
      return;
    end
    pr_acc = pr_acc * base + d;
    if (pr_count < 2'd2)
      pr_count = pr_count + 2'd1;
  endfunction

  // Advance the parser by one character; return 1 with the number when the
  // character closes the string.
  function automatic bit parse_char(logic [7:0] c, logic lst, output out_item_t res);
    logic [63:0] mask;
    logic [63:0] signed_val;
    res = '0;
    if (pr_phase == PH_SPACE) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        pr_space = 1'b1;
      end else if (c == CH_MINUS) begin
        pr_neg   = 1'b1;
        pr_phase = PH_DIGITS;
      end else if (c == CH_PLUS) begin
        pr_phase = PH_DIGITS;
      end else begin
        pr_phase = PH_DIGITS;
        take_digit(c, lst);
      end
    end else if (pr_phase == PH_DIGITS) begin
      take_digit(c, lst);
    end
    if (!lst)
      return 1'b0;
    // Reduce to the target width in force at the closing character.
    mask = (!shadow_cfg.hex_mode && shadow_cfg.target_wide) ?
           64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    signed_val     = pr_neg ? (64'd0 - pr_acc) : pr_acc;
    res.value      = signed_val & mask;
    res.valid_res  = !pr_space && pr_stop == STOP_NONE && pr_count != 2'd0 &&
                     pr_phase != PH_SPACE;
    res.overflowed = (pr_stop == STOP_OVERFLOW);
    pr_phase = PH_SPACE;
    pr_acc   = '0;
    pr_neg   = 1'b0;
    pr_space = 1'b0;
    pr_count = 2'd0;
    pr_stop  = STOP_NONE;
    return 1'b1;
  endfunction

  function automatic void complain(string msg);
    bad_results++;
    if (bad_results <= 10)
      $display("%s", msg);
  endfunction

  function automatic void add_row(string text, cfg_t mode, bit typed,
                                  logic [63:0] value, bit ok, bit ovf);
    str_case_t row;
    row.text            = text;
    row.mode            = mode;
    row.typed           = typed;
    row.want.value      = value;
    row.want.valid_res  = ok;
    row.want.overflowed = ovf;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // --------------------------------------------------------------------------
  // Send str_buf one item per character. Mark the final character as last
  // only when closes is set. Valid stays high after the final acceptance;
  // the next call or settle() decides what it does in that same step.
  // --------------------------------------------------------------------------
  task automatic send_text(input bit closes);
    logic      lst;
    out_item_t number;
    for (int i = 0; i < str_buf.size(); i++) begin
      lst = closes && (i == str_buf.size() - 1);
      // Idle the sender at random before this item.
      while ($urandom_range(99) < send_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= {str_buf[i], lst};
      do @(posedge clk); while (in_stall);
      // Accepted at this edge: predict with the registers now in force.
      if (parse_char(str_buf[i], lst, number))
        pending_numbers.insert(pending_numbers.size(), pin_next ? pinned : number);
    end
  endtask

  // Drop valid, wait for every owed number, then give the pipeline time to
  // swallow characters that produce no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_numbers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while the block is idle.
  task automatic set_config(input cfg_t want);
    logic [1:0] order [3];
    logic       bit_val;
    order = '{CFG_HEX_MODE, CFG_TARGET_SIGNED, CFG_TARGET_WIDE};
    settle();
    foreach (order[k]) begin
      case (order[k])
        CFG_HEX_MODE:      bit_val = want.hex_mode;
        CFG_TARGET_SIGNED: bit_val = want.target_signed;
        CFG_TARGET_WIDE:   bit_val = want.target_wide;
        default:           bit_val = 1'b0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= bit_val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    shadow_cfg = want;
  endtask

  // --------------------------------------------------------------------------
  // Build one random string for the current target. Most are well formed:
  // optional blanks, sign and hex prefix, then digits. A share lands right
  // at the target limit, some carry a stray byte, and a share is pure noise.
  // --------------------------------------------------------------------------
  task automatic make_string();
    int          roll;
    int          n;
    int          d;
    bit          neg;
    bit          upper;
    logic [63:0] near;
    string       digits;
    str_buf.delete();
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 5))
        str_buf.insert(str_buf.size(), 8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 2))
        str_buf.insert(str_buf.size(), ($urandom_range(5) == 0) ? CH_SPACE :
                       CH_TAB + 8'($urandom_range(4)));
    end
    neg = 1'b0;
    case ($urandom_range(3))
      0: begin
        neg = 1'b1;
        str_buf.insert(str_buf.size(), CH_MINUS);
      end
      1: str_buf.insert(str_buf.size(), CH_PLUS);
      default: ;
    endcase
    if (shadow_cfg.hex_mode && $urandom_range(2) == 0) begin
      str_buf.insert(str_buf.size(), CH_ZERO);
      str_buf.insert(str_buf.size(), $urandom_range(1) ? CH_UP_X : CH_LO_X);
    end
    upper = 1'($urandom_range(1));
    if (roll < 40) begin
      // One below the limit, on it, or one past it.
      near   = magnitude_cap(shadow_cfg, neg) + 64'($urandom_range(2)) - 64'd1;
      digits = shadow_cfg.hex_mode ? $sformatf("%0h", near) : $sformatf("%0d", near);
      if (upper)
        digits = digits.toupper();
      for (int i = 0; i < digits.len(); i++)
        str_buf.insert(str_buf.size(), digits[i]);
      if ($urandom_range(3) == 0)
        str_buf.insert(str_buf.size(), CH_ZERO + 8'($urandom_range(9)));
    end else begin
      n = ($urandom_range(7) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 6);
      repeat (n) begin
        d = shadow_cfg.hex_mode ? $urandom_range(15) : $urandom_range(9);
        if (d < 10)
          str_buf.insert(str_buf.size(), CH_ZERO + 8'(d));
        else
          str_buf.insert(str_buf.size(), (upper ? CH_UP_A : CH_LO_A) + 8'(d - 10));
      end
    end
    // Break some strings with a stray byte anywhere.
    if (roll < 20)
      str_buf.insert($urandom_range(str_buf.size()), 8'($urandom_range(255)));
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted item, stall at random, and serve long
  // hold-offs counted here.
  // --------------------------------------------------------------------------
  initial begin : result_side
    int        hold_left;
    int        holds_served;
    out_item_t want;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_numbers.size() == 0) begin
          complain($sformatf("unexpected result: value %h valid_res %b overflowed %b",
                             out_data.value, out_data.valid_res, out_data.overflowed));
        end else begin
          want = pending_numbers.pop_front();
          if (out_data.value !== want.value || out_data.valid_res !== want.valid_res ||
              out_data.overflowed !== want.overflowed)
            complain($sformatf("mismatch: expected %h/%b/%b, got %h/%b/%b",
                               want.value, want.valid_res, want.overflowed,
                               out_data.value, out_data.valid_res, out_data.overflowed));
        end
      end
      if (holds_asked != holds_served) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int keep;
    int spins;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_HEX_MODE;
    cfg_data    = 1'b0;
    pin_next    = 1'b0;
    pinned      = '0;
    bad_results = 0;
    holds_asked = 0;
    send_pct    = 24;
    recv_pct    = 73;

    // Corner strings; typed numbers where they are plain to see.
    add_row("0",           MODE_I32, 1'b1, 64'd0,         1'b1, 1'b0);
    add_row("2147483647",  MODE_I32, 1'b1, 64'h7FFF_FFFF, 1'b1, 1'b0);
    add_row("2147483648",  MODE_I32, 1'b1, 64'h7FFF_FFFF, 1'b0, 1'b1);
    add_row("-2147483648", MODE_I32, 1'b1, 64'h8000_0000, 1'b1, 1'b0);
    add_row("-2147483649", MODE_I32, 1'b1, 64'h8000_0000, 1'b0, 1'b1);
    add_row(" \t42",       MODE_I32, 1'b1, 64'd42,        1'b0, 1'b0);
    add_row("+",           MODE_I32, 1'b1, 64'd0,         1'b0, 1'b0);
    add_row(" \n-",        MODE_I32, 1'b1, 64'd0,         1'b0, 1'b0);
    add_row("12a\377",     MODE_I32, 1'b1, 64'd12,        1'b0, 1'b0);
    add_row("+-7",         MODE_I32, 1'b1, 64'd0,         1'b0, 1'b0);
    add_row("-31",         MODE_I32, 1'b0, 64'd0,         1'b0, 1'b0);
    add_row("4294967295",  MODE_U32, 1'b1, 64'hFFFF_FFFF, 1'b1, 1'b0);
    add_row("4294967296",  MODE_U32, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b1);
    add_row("-7",          MODE_U32, 1'b1, 64'd0,         1'b0, 1'b1);
    add_row("-0",          MODE_U32, 1'b1, 64'd0,         1'b1, 1'b0);
    add_row("18446744073709551615", MODE_U64, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    add_row("18446744073709551616", MODE_U64, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    add_row("-9223372036854775808", MODE_I64, 1'b1, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_row("9223372036854775808",  MODE_I64, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    add_row("0xFFFFFFFF",  MODE_HEX, 1'b1, 64'hFFFF_FFFF, 1'b1, 1'b0);
    add_row("-0X80000000", MODE_HEX, 1'b1, 64'h8000_0000, 1'b1, 1'b0);
    add_row("0x100000000", MODE_HEX, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b1);
    add_row("0x",          MODE_HEX, 1'b1, 64'd0,         1'b0, 1'b0);
    add_row("-aBcDeF",     MODE_HEX, 1'b0, 64'd0,         1'b0, 1'b0);
    add_row("-80000001",   MODE_HEX, 1'b1, 64'h8000_0000, 1'b0, 1'b1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; the first rows run on the reset register values.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != shadow_cfg)
        set_config(dir_rows[r].mode);
      str_buf.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        str_buf.insert(str_buf.size(), dir_rows[r].text[i]);
      pin_next = dir_rows[r].typed;
      pinned   = dir_rows[r].want;
      send_text(1'b1);
    end
    pin_next = 1'b0;

    // Narrow the target in the middle of a string: "-5" as int64, then the
    // closing "0" as int32, so -50 comes back reduced to 32 bits.
    set_config(MODE_I64);
    str_buf = '{CH_MINUS, CH_ZERO + 8'd5};
    send_text(1'b0);
    set_config(MODE_I32);
    str_buf = '{CH_ZERO};
    send_text(1'b1);

    // Random strings: slow sender / busy receiver, then the reverse, then
    // both at full rate.
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          send_pct = 24;
          recv_pct = 73;
        end
        1: begin
          send_pct = 73;
          recv_pct = 24;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      set_config(cfg_t'(3'($urandom_range(7))));
      // Hold the receiver off and keep offering one-digit strings so the
      // block backs up and stalls its input.
      holds_asked++;
      keep     = send_pct;
      send_pct = 0;
      repeat (BURST_ITEMS) begin
        str_buf = '{CH_ZERO + 8'($urandom_range(9))};
        send_text(1'b1);
      end
      send_pct = keep;
      repeat (3) begin
        set_config(cfg_t'(3'($urandom_range(7))));
        sent = 0;
        while (sent < PHASE_CHARS) begin
          make_string();
          sent += str_buf.size();
          send_text(1'b1);
        end
      end
    end

    // Wait out the last results, bounded, then a few more cycles.
    in_valid <= 1'b0;
    spins = 0;
    while (pending_numbers.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (pending_numbers.size() != 0)
      complain($sformatf("%0d results never arrived", pending_numbers.size()));

    if (bad_results == 0)
      $display("** text_to_integer_parser: PASSED **");
    else
      $display("** text_to_integer_parser: FAILED **");
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("** text_to_integer_parser: FAILED **");
    $finish;
  end

endmodule
